>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the lexer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer assertion failed");

// Next-cycle implication, disabled during reset.
`define CLU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

`endif

>>> hw/rtl/clu_pkg.sv
// Types, token codes, character classes and keyword table of the lexer.
// No dependencies; imported by every lexer module.
package clu_pkg;

   localparam int HEAD_W = 64;

   localparam logic [2:0] KIND_KEYWORD = 3'd0;
   localparam logic [2:0] KIND_IDENT   = 3'd1;
   localparam logic [2:0] KIND_NUMBER  = 3'd2;
   localparam logic [2:0] KIND_OPER    = 3'd3;
   localparam logic [2:0] KIND_SPECIAL = 3'd4;
   localparam logic [2:0] KIND_END     = 3'd5;

   localparam logic [2:0] KW_NONE = 3'd7;
   localparam int         KW_COUNT = 7;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_QUOTE   = 8'h22;

   localparam logic [15:0] LINE_MAX = 16'hFFFF;
   localparam logic [11:0] COL_MAX  = 12'hFFF;

   // keywords packed first character in the low byte
   localparam logic [HEAD_W-1:0] KW_WORD [KW_COUNT] = '{
      64'h0000_0000_0074_6E69,   // int
      64'h0000_0000_7261_6863,   // char
      64'h0000_0074_616F_6C66,   // float
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6573_6C65,   // else
      64'h0000_0065_6C69_6877,   // while
      64'h0000_6E72_7574_6572    // return
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5, 4'd6};

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } clu_req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [2:0]        keyword_index;
      logic [HEAD_W-1:0] lexeme_head;
      logic [4:0]        lexeme_length;
      logic              too_long;
      logic [15:0]       line;
      logic [11:0]       column;
      logic              last;
   } clu_rsp_type;

   typedef struct packed {
      logic letter;
      logic digit;
      logic newline;
      logic slash;
      logic star;
      logic hash;
      logic quote;
      logic oper;      // + - * < > = !  (slash handled apart)
      logic special;   // ; ( ) { } [ ] ,
   } clu_class_type;

   typedef struct packed {
      clu_req_type   req;
      clu_class_type cls;
   } clu_item_type;

   function automatic clu_class_type classify(input logic [7:0] c);
      clu_class_type r;
      r = '0;
      r.letter  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
      r.digit   = (c >= 8'h30 && c <= 8'h39);
      r.newline = (c == CH_NEWLINE);
      r.slash   = (c == CH_SLASH);
      r.star    = (c == CH_STAR);
      r.hash    = (c == CH_HASH);
      r.quote   = (c == CH_QUOTE);
      case (c) inside
         8'h2B, 8'h2D, 8'h2A, 8'h3C, 8'h3E, 8'h3D, 8'h21: r.oper = 1'b1;
         8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C: r.special = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_lookup(input logic [HEAD_W-1:0] head,
                                           input logic [3:0] len);
      logic [2:0] r;
      r = KW_NONE;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (r == KW_NONE && KW_LEN[k] == len && KW_WORD[k] == head)
            r = 3'(k);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/clu_front.sv
// Front end: classifies each accepted character and holds it in a two-entry queue.
// Depends on clu_pkg.
module clu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  clu_pkg::clu_req_type req_data,
   output logic                 item_valid,
   input  logic                 item_ready,
   output clu_pkg::clu_item_type item
);
   import clu_pkg::*;

   clu_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff].req <= req_data;
         q_ff[wr_ptr_ff].cls <= classify(req_data.ch);
      end
   end

endmodule

>>> hw/rtl/clu_scanner.sv
// Back end: scan state machine, position tracking and token assembly.
// Depends on clu_pkg; makes up to two tokens per character.
module clu_scanner #(
   parameter int MAX_LEXEME = 29,
   parameter int HEAD_CHARS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  clu_pkg::clu_item_type item,
   input  logic                  tok_room,
   output logic                  tok0_valid,
   output clu_pkg::clu_rsp_type  tok0,
   output logic                  tok1_valid,
   output clu_pkg::clu_rsp_type  tok1
);
   import clu_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEXEME + 1);

   typedef enum logic [7:0] {
      MODE_IDLE      = 8'b0000_0001,
      MODE_IDENT     = 8'b0000_0010,
      MODE_NUMBER    = 8'b0000_0100,
      MODE_SLASH     = 8'b0000_1000,
      MODE_LINESKIP  = 8'b0001_0000,
      MODE_BLOCK     = 8'b0010_0000,
      MODE_BLOCKSTAR = 8'b0100_0000,
      MODE_STRING    = 8'b1000_0000
   } mode_type;

   mode_type          mode_ff, mode_in, scan;
   logic [15:0]       line_ff, line_in;
   logic [11:0]       col_ff, col_in;
   logic [11:0]       start_ff, start_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;

   logic              pop, flush, pending;
   logic [2:0]        kw;
   clu_rsp_type       flush_tok;
   logic [7:0]        c;
   clu_class_type     cls;

   assign item_ready = tok_room;
   assign pop        = item_valid && tok_room;
   assign c          = item.req.ch;
   assign cls        = item.cls;
   assign pending    = (mode_ff == MODE_IDENT) || (mode_ff == MODE_NUMBER) ||
                       (mode_ff == MODE_SLASH);

   // token for a pending identifier, number or held slash
   always_comb begin
      kw = (ovf_ff || len_ff > LEN_W'(HEAD_CHARS)) ? KW_NONE : kw_lookup(head_ff, len_ff[3:0]);
      flush_tok               = '0;
      flush_tok.keyword_index = KW_NONE;
      flush_tok.line          = line_ff;
      flush_tok.column        = start_ff;
      flush_tok.lexeme_head   = head_ff;
      flush_tok.lexeme_length = 5'(len_ff);
      flush_tok.too_long      = ovf_ff;
      if (mode_ff == MODE_IDENT) begin
         flush_tok.kind          = (kw != KW_NONE) ? KIND_KEYWORD : KIND_IDENT;
         flush_tok.keyword_index = kw;
      end else if (mode_ff == MODE_NUMBER) begin
         flush_tok.kind = KIND_NUMBER;
      end else begin
         flush_tok.kind          = KIND_OPER;
         flush_tok.lexeme_head   = HEAD_W'(CH_SLASH);
         flush_tok.lexeme_length = 5'd1;
         flush_tok.too_long      = 1'b0;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      start_in = start_ff;
      head_in  = head_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      flush    = 1'b0;
      scan     = mode_ff;

      tok0_valid = 1'b0;
      tok0       = flush_tok;
      tok1_valid = 1'b0;
      tok1               = '0;
      tok1.keyword_index = KW_NONE;

      if (pop && item.req.end_of_text) begin
         tok0_valid    = pending;
         tok1_valid    = 1'b1;
         tok1.kind     = KIND_END;
         tok1.line     = line_ff;
         tok1.column   = col_ff;
         mode_in  = MODE_IDLE;
         line_in  = 16'd1;
         col_in   = '0;
         start_in = '0;
         head_in  = '0;
         len_in   = '0;
         ovf_in   = 1'b0;
      end else if (pop) begin
         flush = ((mode_ff == MODE_IDENT) && !(cls.letter || cls.digit)) ||
                 ((mode_ff == MODE_NUMBER) && !cls.digit) ||
                 ((mode_ff == MODE_SLASH) && !cls.slash && !cls.star);
         tok0_valid = flush;
         scan       = flush ? MODE_IDLE : mode_ff;

         if (cls.newline) begin
            if (line_ff != LINE_MAX)
               line_in = line_ff + 16'd1;
            col_in = '0;
         end else if (col_ff != COL_MAX) begin
            col_in = col_ff + 12'd1;
         end

         tok1.line   = line_in;
         tok1.column = col_in;
         tok1.lexeme_head   = HEAD_W'(c);
         tok1.lexeme_length = 5'd1;

         unique case (scan) inside
            MODE_IDENT, MODE_NUMBER: begin
               for (int i = 0; i < 8; i++) begin
                  if (i < HEAD_CHARS && len_ff == LEN_W'(i))
                     head_in[8*i +: 8] = c;
               end
               if (len_ff < LEN_W'(MAX_LEXEME))
                  len_in = len_ff + LEN_W'(1);
               else
                  ovf_in = 1'b1;
            end
            MODE_SLASH: begin
               mode_in = cls.slash ? MODE_LINESKIP : MODE_BLOCK;
            end
            MODE_LINESKIP: begin
               if (cls.newline)
                  mode_in = MODE_IDLE;
            end
            MODE_BLOCK: begin
               if (cls.star)
                  mode_in = MODE_BLOCKSTAR;
            end
            MODE_BLOCKSTAR: begin
               if (cls.slash)
                  mode_in = MODE_IDLE;
               else if (!cls.star)
                  mode_in = MODE_BLOCK;
            end
            MODE_STRING: begin
               if (cls.quote)
                  mode_in = MODE_IDLE;
            end
            default: begin
               mode_in = MODE_IDLE;
               if (cls.hash) begin
                  mode_in = MODE_LINESKIP;
               end else if (cls.quote) begin
                  mode_in = MODE_STRING;
               end else if (cls.slash) begin
                  mode_in  = MODE_SLASH;
                  start_in = col_in;
               end else if (cls.letter || cls.digit) begin
                  mode_in  = cls.letter ? MODE_IDENT : MODE_NUMBER;
                  head_in  = HEAD_W'(c);
                  len_in   = LEN_W'(1);
                  ovf_in   = 1'b0;
                  start_in = col_in;
               end else if (cls.oper) begin
                  tok1_valid = 1'b1;
                  tok1.kind  = KIND_OPER;
               end else if (cls.special) begin
                  tok1_valid = 1'b1;
                  tok1.kind  = KIND_SPECIAL;
               end
            end
         endcase
      end

      tok0.last = !tok1_valid;
      tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= 16'd1;
         col_ff   <= '0;
         start_ff <= '0;
         head_ff  <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         head_ff  <= head_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

>>> hw/rtl/clu_token_queue.sv
// Output queue: takes up to two tokens a cycle, hands out one per transfer.
// Depends on clu_pkg.
module clu_token_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push0_valid,
   input  clu_pkg::clu_rsp_type push0,
   input  logic                 push1_valid,
   input  clu_pkg::clu_rsp_type push1,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output clu_pkg::clu_rsp_type rsp_data
);
   import clu_pkg::*;

   localparam int DEPTH = 4;

   clu_rsp_type q_ff [DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  n_push;
   logic        pop;
   clu_rsp_type first;

   // room for a worst-case pair of tokens
   assign room      = (count_ff < 3'(DEPTH - 1));
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      n_push    = 2'(push0_valid) + 2'(push1_valid);
      first     = push0_valid ? push0 : push1;
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(n_push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0)
         q_ff[wr_ptr_ff] <= first;
      if (n_push == 2'd2)
         q_ff[wr_ptr_ff + 2'd1] <= push1;
   end

endmodule

>>> hw/rtl/c_subset_lexer_unit.sv
// A character is registered in the front queue, and a token that it completes in the output
// queue, before rsp offers it; identifiers, numbers and a held slash complete on the next one.
// One character per cycle; req stalls once the front queue fills while 3+ tokens are queued.
// A character that yields two tokens (or end of text after a pending token) drains them
// one per cycle while rsp_ready is high, through the four-entry output queue.
// Reset (synchronous, active high) empties both queues and returns position to line 1.
module c_subset_lexer_unit #(
   parameter int MAX_LEXEME = 29,
   parameter int HEAD_CHARS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  clu_pkg::clu_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output clu_pkg::clu_rsp_type rsp_data
);
   import clu_pkg::*;

   logic         item_valid, item_ready;
   clu_item_type item;
   logic         tok_room;
   logic         tok0_valid, tok1_valid;
   clu_rsp_type  tok0, tok1;

   clu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   clu_scanner #(
      .MAX_LEXEME (MAX_LEXEME),
      .HEAD_CHARS (HEAD_CHARS)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .tok_room   (tok_room),
      .tok0_valid (tok0_valid),
      .tok0       (tok0),
      .tok1_valid (tok1_valid),
      .tok1       (tok1)
   );

   clu_token_queue u_tokq (
      .clock       (clock),
      .reset       (reset),
      .push0_valid (tok0_valid),
      .push0       (tok0),
      .push1_valid (tok1_valid),
      .push1       (tok1),
      .room        (tok_room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

>>> hw/rtl/clu_checker.sv
// Port-level checks on the lexer's character and token streams, bound to the top level.
// Depends on clu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clu_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input clu_pkg::clu_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input clu_pkg::clu_rsp_type rsp_data
);
   import clu_pkg::*;

   logic rsp_stall, req_stall, rsp_end, rsp_other;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_stall = req_valid && !req_ready;
   assign rsp_end   = rsp_valid && (rsp_data.kind == KIND_END);
   assign rsp_other = rsp_valid && (rsp_data.kind != KIND_KEYWORD);

   `CLU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `CLU_ASSERT_NXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_data))
   `CLU_ASSERT_IMP(a_end_last, clock, reset, rsp_end, rsp_data.last && rsp_data.lexeme_length == '0)
   `CLU_ASSERT_IMP(a_kw_none, clock, reset, rsp_other, rsp_data.keyword_index == KW_NONE)
   `CLU_ASSERT_IMP(a_line_nonzero, clock, reset, rsp_valid, rsp_data.line != 16'd0)

endmodule

bind c_subset_lexer_unit clu_checker u_clu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for c_subset_lexer_unit: streams characters in, checks every token.
// Depends on clu_pkg (request/response structs, token kind codes, character constants).
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import clu_pkg::*;

   localparam int MAX_LEX     = 29;
   localparam int HEAD_BYTES  = 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 120;
   localparam int IDLE_PCT    = 34;

   typedef enum logic [7:0] {
      SCAN_IDLE         = 8'b0000_0001,
      SCAN_WORD         = 8'b0000_0010,
      SCAN_NUM          = 8'b0000_0100,
      SCAN_SLASH        = 8'b0000_1000,
      SCAN_SKIPLINE     = 8'b0001_0000,
      SCAN_COMMENT      = 8'b0010_0000,
      SCAN_COMMENT_STAR = 8'b0100_0000,
      SCAN_STRING       = 8'b1000_0000
   } scan_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   clu_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   clu_rsp_type rsp_data;

   c_subset_lexer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // character stream waiting to be sent, tokens waiting to come back
   clu_req_type char_queue [$];
   clu_rsp_type expected_tokens [$];
   clu_rsp_type step_tokens [$];

   string kw_text [7] = '{"int", "char", "float", "if", "else", "while", "return"};
   string id_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string id_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

   logic burst_mode  = 1'b0;
   logic stall_armed = 1'b0;
   logic stall_done  = 1'b0;
   int   stall_left  = 0;

   int mismatches      = 0;
   int chars_sent      = 0;
   int tokens_checked  = 0;
   int keywords_seen   = 0;
   int overlong_seen   = 0;
   int ends_seen       = 0;
   int deepest_line    = 0;
   int widest_column   = 0;

   // scanner state mirrored by the predictor
   scan_state_type scan_st = SCAN_IDLE;
   logic [15:0] cur_line = 16'd1;
   logic [11:0] cur_col  = '0;
   logic [11:0] tok_col  = '0;
   logic [63:0] tok_head = '0;
   logic [4:0]  tok_len  = '0;
   logic        tok_over = 1'b0;

   // ---------------- stimulus helpers ----------------
   function automatic void add_byte(logic [7:0] c);
      char_queue.push_back(clu_req_type'{ch: c, end_of_text: 1'b0});
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_end();
      // character field carries junk, it must be ignored
      char_queue.push_back(clu_req_type'{ch: 8'($urandom_range(255)), end_of_text: 1'b1});
   endfunction

   function automatic logic [7:0] pick_from(string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function automatic logic [7:0] junk_char();
      case ($urandom_range(9))
         0: return CH_STAR;
         1: return CH_NEWLINE;
         2: return CH_SLASH;
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic int lexeme_size();
      return ($urandom_range(19) == 0) ? $urandom_range(9, 36) : $urandom_range(1, 6);
   endfunction

   // one well-formed fragment of source text, or a bit of noise; returns items that count
   function automatic int add_fragment();
      int sel;
      int len;
      int start;
      start = char_queue.size();
      sel = $urandom_range(99);
      if (sel < 12) begin
         add_text(kw_text[$urandom_range(6)]);
      end else if (sel < 30) begin
         len = lexeme_size();
         add_byte(pick_from(id_head));
         repeat (len - 1) add_byte(pick_from(id_tail));
      end else if (sel < 40) begin
         len = lexeme_size();
         repeat (len) add_byte(pick_from("0123456789"));
      end else if (sel < 50) begin
         add_byte(pick_from("+-*/<>=!"));
      end else if (sel < 60) begin
         add_byte(pick_from(";(){}[],"));
      end else if (sel < 70) begin
         add_byte(pick_from(" \t\n\r "));
      end else if (sel < 75) begin
         add_text("//");
         repeat ($urandom_range(6)) add_byte(junk_char());
         add_byte(CH_NEWLINE);
      end else if (sel < 80) begin
         add_text("/*");
         repeat ($urandom_range(8)) add_byte(junk_char());
         add_text("*/");
      end else if (sel < 84) begin
         add_byte(CH_QUOTE);
         repeat ($urandom_range(6)) add_byte(junk_char());
         add_byte(CH_QUOTE);
      end else if (sel < 87) begin
         add_byte(CH_HASH);
         repeat ($urandom_range(5)) add_byte(junk_char());
         add_byte(CH_NEWLINE);
      end else if (sel < 96) begin
         add_byte(8'($urandom_range(255)));
         return 0;
      end else begin
         add_end();
      end
      return char_queue.size() - start;
   endfunction

   function automatic void fill_random(int count);
      int added;
      added = 0;
      while (added < count) added += add_fragment();
   endfunction

   // ---------------- token predictor ----------------
   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void push_token(logic [2:0] kind, logic [2:0] kw, logic [63:0] head,
                                      logic [4:0] len, logic over, logic [11:0] col);
      clu_rsp_type t;
      t.kind          = kind;
      t.keyword_index = kw;
      t.lexeme_head   = head;
      t.lexeme_length = len;
      t.too_long      = over;
      t.line          = cur_line;
      t.column        = col;
      t.last          = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic logic [2:0] keyword_of();
      logic [63:0] word;
      for (int k = 0; k < 7; k++) begin
         word = '0;
         for (int i = 0; i < kw_text[k].len(); i++) word[8*i +: 8] = kw_text[k][i];
         if (!tok_over && tok_len == kw_text[k].len() && word == tok_head) return 3'(k);
      end
      return KW_NONE;
   endfunction

   function automatic void flush_token();
      logic [2:0] kw;
      case (scan_st)
         SCAN_WORD: begin
            kw = keyword_of();
            push_token((kw == KW_NONE) ? KIND_IDENT : KIND_KEYWORD, kw, tok_head, tok_len,
                       tok_over, tok_col);
         end
         SCAN_NUM:   push_token(KIND_NUMBER, KW_NONE, tok_head, tok_len, tok_over, tok_col);
         SCAN_SLASH: push_token(KIND_OPER, KW_NONE, 64'(CH_SLASH), 5'd1, 1'b0, tok_col);
         default: return;
      endcase
      scan_st = SCAN_IDLE;
   endfunction

   function automatic void start_lexeme(logic [7:0] c, scan_state_type st);
      tok_head = 64'(c);
      tok_len  = 5'd1;
      tok_over = 1'b0;
      tok_col  = cur_col;
      scan_st  = st;
   endfunction

   function automatic void predict_tokens(clu_req_type r);
      logic [7:0] c;
      c = r.ch;
      step_tokens.delete();
      if (r.end_of_text) begin
         flush_token();
         push_token(KIND_END, KW_NONE, '0, '0, 1'b0, cur_col);
         scan_st  = SCAN_IDLE;
         cur_line = 16'd1;
         cur_col  = '0;
         tok_col  = '0;
         tok_head = '0;
         tok_len  = '0;
         tok_over = 1'b0;
      end else begin
         // a character that ends a pending token emits it, then is scanned afresh
         if ((scan_st == SCAN_WORD && !(is_alpha(c) || is_dec(c))) ||
             (scan_st == SCAN_NUM && !is_dec(c)) ||
             (scan_st == SCAN_SLASH && c != CH_SLASH && c != CH_STAR))
            flush_token();

         if (c == CH_NEWLINE) begin
            if (cur_line != LINE_MAX) cur_line++;
            cur_col = '0;
         end else if (cur_col != COL_MAX) begin
            cur_col++;
         end

         case (scan_st) inside
            SCAN_WORD, SCAN_NUM: begin
               if (tok_len < HEAD_BYTES) tok_head[8*tok_len +: 8] = c;
               if (tok_len < MAX_LEX) tok_len++;
               else tok_over = 1'b1;
            end
            SCAN_SLASH: scan_st = (c == CH_SLASH) ? SCAN_SKIPLINE : SCAN_COMMENT;
            SCAN_SKIPLINE: if (c == CH_NEWLINE) scan_st = SCAN_IDLE;
            SCAN_COMMENT: if (c == CH_STAR) scan_st = SCAN_COMMENT_STAR;
            SCAN_COMMENT_STAR: begin
               if (c == CH_SLASH) scan_st = SCAN_IDLE;
               else if (c != CH_STAR) scan_st = SCAN_COMMENT;
            end
            SCAN_STRING: if (c == CH_QUOTE) scan_st = SCAN_IDLE;
            default: begin
               if (c == CH_HASH) begin
                  scan_st = SCAN_SKIPLINE;
               end else if (c == CH_QUOTE) begin
                  scan_st = SCAN_STRING;
               end else if (c == CH_SLASH) begin
                  scan_st = SCAN_SLASH;
                  tok_col = cur_col;
               end else if (is_alpha(c)) begin
                  start_lexeme(c, SCAN_WORD);
               end else if (is_dec(c)) begin
                  start_lexeme(c, SCAN_NUM);
               end else begin
                  case (c) inside
                     "+", "-", "*", "<", ">", "=", "!":
                        push_token(KIND_OPER, KW_NONE, 64'(c), 5'd1, 1'b0, cur_col);
                     ";", "(", ")", "{", "}", "[", "]", ",":
                        push_token(KIND_SPECIAL, KW_NONE, 64'(c), 5'd1, 1'b0, cur_col);
                     default: ;
                  endcase
               end
            end
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch at token %0d, %s: got %0h expected %0h",
               tokens_checked, field, got, want);
      mismatches++;
   endtask

   task automatic check_token(clu_rsp_type got);
      clu_rsp_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("token with none pending", 64'(got.kind), '0);
      end else begin
         want = expected_tokens.pop_front();
         if (got.kind != want.kind) report_mismatch("kind", 64'(got.kind), 64'(want.kind));
         if (got.keyword_index != want.keyword_index)
            report_mismatch("keyword_index", 64'(got.keyword_index),
                            64'(want.keyword_index));
         if (got.lexeme_head != want.lexeme_head)
            report_mismatch("lexeme_head", got.lexeme_head, want.lexeme_head);
         if (got.lexeme_length != want.lexeme_length)
            report_mismatch("lexeme_length", 64'(got.lexeme_length),
                            64'(want.lexeme_length));
         if (got.too_long != want.too_long)
            report_mismatch("too_long", 64'(got.too_long), 64'(want.too_long));
         if (got.line != want.line) report_mismatch("line", 64'(got.line), 64'(want.line));
         if (got.column != want.column)
            report_mismatch("column", 64'(got.column), 64'(want.column));
         if (got.last != want.last) report_mismatch("last", 64'(got.last), 64'(want.last));
         if (want.kind == KIND_KEYWORD) keywords_seen++;
         if (want.kind == KIND_END) ends_seen++;
         if (want.too_long) overlong_seen++;
         if (int'(want.line) > deepest_line) deepest_line = int'(want.line);
         if (int'(want.column) > widest_column) widest_column = int'(want.column);
      end
      tokens_checked++;
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_tokens(req_data);
            chars_sent++;
         end
         if (!req_valid || req_ready) begin
            if (char_queue.size() > 0 && (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= char_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_token(rsp_data);
         // one long hold-off so the output queue fills and req backs up
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (stall_armed && !stall_done) begin
            stall_left <= HOLD_CYCLES;
            stall_done <= 1'b1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ---------------- watchdog ----------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL c_subset_lexer_unit");
      $finish;
   end

   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_drained();
      while (char_queue.size() != 0 || req_valid) @(negedge clock);
      while (expected_tokens.size() != 0) @(negedge clock);
   endtask

   // ---------------- test sequence ----------------
   initial begin : sequence_main
      int chunk;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every keyword, operator and symbol, skipped constructs, held slash
      add_text("int char float if else while return\n");
      add_text("in intx _a9 Z 0 9 42 +-*<>=! ;(){}[],\n");
      add_byte(8'h80);
      add_byte(8'hFF);
      add_byte(8'h00);
      add_byte(8'h7F);
      add_text("a/b/ c #define x\n//note\n/*a*\n**/\"s\n\"/=/");
      add_end();
      add_text("abcdefghijklmnopqrstuvwxyz_AB abcdefghijklmnopqrstuvwxyz_ABC ");
      add_text("0123456789012345678901234567890123456789 returnx return\n/*open");
      add_end();
      add_text("x9");
      add_end();
      add_end();
      wait_drained();

      // receiver holds off while two-token pairs keep coming
      stall_armed = 1'b1;
      repeat (40) add_text("a;");
      add_end();
      wait_drained();

      for (chunk = 0; chunk < 6; chunk++) begin
         burst_mode = (chunk == 2);
         fill_random(55);
         if (chunk == 3) wait_drained();
      end
      add_end();
      wait_drained();
      burst_mode = 1'b0;

      repeat (10) @(posedge clock);
      if (expected_tokens.size() != 0)
         report_mismatch("tokens never produced", 64'(expected_tokens.size()), '0);
      $display("sent %0d characters; checked %0d tokens (%0d keywords, %0d overlong, %0d ends)",
               chars_sent, tokens_checked, keywords_seen, overlong_seen, ends_seen);
      $display("reached line %0d and column %0d", deepest_line, widest_column);
      if (mismatches == 0)
         $display("PASS c_subset_lexer_unit");
      else
         $display("FAIL c_subset_lexer_unit");
      $finish;
   end

endmodule

>>> c_subset_lexer_unit.f
+incdir+hw/rtl
hw/rtl/clu_pkg.sv
hw/rtl/clu_front.sv
hw/rtl/clu_scanner.sv
hw/rtl/clu_token_queue.sv
hw/rtl/c_subset_lexer_unit.sv
hw/rtl/clu_checker.sv
tb/sv/testbench.sv
